// File: src/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Each macro expects clk and arst_n in scope.
`define ASSERT_HOLDS(label, cond) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond)) \
		else $error("assertion failed");

`define ASSERT_IMPL(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

`define ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

// File: src/cstt_pkg.sv
package cstt_pkg;

	localparam int unsigned TABLE_ENTRIES_DEF = 128;
	localparam int unsigned PTR_W = 8;

	localparam logic [1:0] CMD_RECORD = 2'd0;
	localparam logic [1:0] CMD_CLEAR  = 2'd1;
	localparam logic [1:0] CMD_REPORT = 2'd2;
	localparam logic [1:0] CMD_READ   = 2'd3;

	localparam logic [2:0] STS_HIT     = 3'd0;
	localparam logic [2:0] STS_NEW     = 3'd1;
	localparam logic [2:0] STS_DROP    = 3'd2;
	localparam logic [2:0] STS_REPORT  = 3'd3;
	localparam logic [2:0] STS_END     = 3'd4;
	localparam logic [2:0] STS_CLEARED = 3'd5;
	localparam logic [2:0] STS_READ    = 3'd6;

	typedef struct packed {
		logic [63:0] key;
		logic [31:0] line;
	} kl_t;

	typedef struct packed {
		logic [31:0] calls;
		logic [47:0] bytes;
	} cb_t;

	typedef struct packed {
		logic             we_kl;
		logic             we_cb;
		logic [PTR_W-1:0] waddr;
		logic [PTR_W-1:0] raddr;
		kl_t              kl_wdata;
		cb_t              cb_wdata;
	} mem_req_t;

	typedef struct packed {
		logic [2:0]       status;
		logic [63:0]      entry_key;
		logic [31:0]      entry_line;
		logic [31:0]      entry_calls;
		logic [47:0]      entry_bytes;
		logic [PTR_W-1:0] entries_used;
		logic [31:0]      dropped_calls;
		logic             last;
	} out_item_t;

endpackage

// File: src/cstt_in_if.sv
interface cstt_in_if;
	import cstt_pkg::*;

	logic             valid;
	logic             ready;
	logic [1:0]       command;
	logic [63:0]      site_key;
	logic [31:0]      site_line;
	logic [31:0]      byte_count;
	logic [5:0]       report_limit;
	logic [PTR_W-1:0] entry_index;

	modport source (
		output valid, command, site_key, site_line, byte_count, report_limit, entry_index,
		input  ready
	);
	modport sink (
		input  valid, command, site_key, site_line, byte_count, report_limit, entry_index,
		output ready
	);
endinterface

// File: src/cstt_out_if.sv
interface cstt_out_if;
	import cstt_pkg::*;

	logic             valid;
	logic             ready;
	logic [2:0]       status;
	logic [63:0]      entry_key;
	logic [31:0]      entry_line;
	logic [31:0]      entry_calls;
	logic [47:0]      entry_bytes;
	logic [PTR_W-1:0] entries_used;
	logic [31:0]      dropped_calls;
	logic             last;

	modport source (
		output valid, status, entry_key, entry_line, entry_calls, entry_bytes,
		       entries_used, dropped_calls, last,
		input  ready
	);
	modport sink (
		input  valid, status, entry_key, entry_line, entry_calls, entry_bytes,
		       entries_used, dropped_calls, last,
		output ready
	);
endinterface

// File: src/cstt_ram.sv
module cstt_ram #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = cstt_pkg::TABLE_ENTRIES_DEF,
	parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

// File: src/cstt_seq.sv
`include "assert_macros.svh"

module cstt_seq #(
	parameter int unsigned TABLE_ENTRIES = cstt_pkg::TABLE_ENTRIES_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	cstt_in_if.sink             request,
	cstt_out_if.source          result,
	output cstt_pkg::mem_req_t  mreq,
	input  cstt_pkg::kl_t       kl_rd,
	input  cstt_pkg::cb_t       cb_rd
);
	import cstt_pkg::*;

	localparam logic [PTR_W-1:0] TE8 = PTR_W'(TABLE_ENTRIES);

	localparam logic [3:0] ST_IDLE  = 4'd0;
	localparam logic [3:0] ST_RSCAN = 4'd1;
	localparam logic [3:0] ST_RMISS = 4'd2;
	localparam logic [3:0] ST_RUPD  = 4'd3;
	localparam logic [3:0] ST_CLR   = 4'd4;
	localparam logic [3:0] ST_READ  = 4'd5;
	localparam logic [3:0] ST_READW = 4'd6;
	localparam logic [3:0] ST_PSCAN = 4'd7;
	localparam logic [3:0] ST_PDONE = 4'd8;

	// control
	logic [3:0]       state_q;
	logic [PTR_W-1:0] ptr_q;
	logic             cmp_vld_s1;
	logic [PTR_W-1:0] used_q;
	logic [31:0]      drop_q;
	logic [5:0]       rpt_n_q;
	logic             ov_q;

	// payload
	logic [63:0]      key_q;
	logic [31:0]      line_q;
	logic [31:0]      bytes_in_q;
	logic [5:0]       lim_q;
	logic [PTR_W-1:0] idx_q;
	logic [PTR_W-1:0] cmp_idx_s1;
	logic [PTR_W-1:0] best_idx_q;
	logic [31:0]      peak_calls_q;
	logic [63:0]      best_key_q;
	logic [31:0]      best_line_q;
	logic [47:0]      best_bytes_q;
	out_item_t        out_q;

	logic             acc;
	logic             issue;
	logic             match;
	logic             better;
	logic             full;
	logic             slot_free;
	logic             rpt_row;
	logic             emit;
	logic [31:0]      drop_inc;
	logic [31:0]      upd_calls;
	logic [48:0]      bsum;
	logic [47:0]      upd_bytes;
	out_item_t        res_d;

	assign acc       = request.valid && request.ready;
	assign issue     = ptr_q < used_q;
	assign match     = cmp_vld_s1 && (kl_rd.key == key_q) && (kl_rd.line == line_q);
	assign better    = cmp_vld_s1 && (cb_rd.calls > peak_calls_q);
	assign full      = used_q >= TE8;
	assign slot_free = !ov_q || result.ready;
	assign rpt_row   = (peak_calls_q != 32'd0) && (rpt_n_q != lim_q);
	assign drop_inc  = (drop_q == '1) ? drop_q : drop_q + 32'd1;
	assign upd_calls = (peak_calls_q == '1) ? peak_calls_q : peak_calls_q + 32'd1;
	assign bsum      = {1'b0, best_bytes_q} + 49'(bytes_in_q);
	assign upd_bytes = bsum[48] ? '1 : bsum[47:0];

	assign request.ready = (state_q == ST_IDLE);

	always_comb begin
		emit                = 1'b0;
		res_d               = '0;
		res_d.entries_used  = used_q;
		res_d.dropped_calls = drop_q;
		res_d.last          = 1'b1;
		mreq                = '0;
		mreq.raddr          = ptr_q;
		case (state_q)
			ST_RMISS: begin
				emit = slot_free;
				if (full) begin
					res_d.status        = STS_DROP;
					res_d.dropped_calls = drop_inc;
				end else begin
					mreq.we_kl          = slot_free;
					mreq.we_cb          = slot_free;
					mreq.waddr          = used_q;
					mreq.kl_wdata.key   = key_q;
					mreq.kl_wdata.line  = line_q;
					mreq.cb_wdata.calls = 32'd1;
					mreq.cb_wdata.bytes = 48'(bytes_in_q);
					res_d.status        = STS_NEW;
					res_d.entry_key     = key_q;
					res_d.entry_line    = line_q;
					res_d.entry_calls   = 32'd1;
					res_d.entry_bytes   = 48'(bytes_in_q);
					res_d.entries_used  = used_q + PTR_W'(1);
				end
			end
			ST_RUPD: begin
				emit                = slot_free;
				mreq.we_cb          = slot_free;
				mreq.waddr          = best_idx_q;
				mreq.cb_wdata.calls = upd_calls;
				mreq.cb_wdata.bytes = upd_bytes;
				res_d.status        = STS_HIT;
				res_d.entry_key     = best_key_q;
				res_d.entry_line    = best_line_q;
				res_d.entry_calls   = upd_calls;
				res_d.entry_bytes   = upd_bytes;
			end
			ST_CLR: begin
				if (issue) begin
					mreq.we_cb = 1'b1;
					mreq.waddr = ptr_q;
				end else begin
					emit                = slot_free;
					res_d.status        = STS_CLEARED;
					res_d.dropped_calls = 32'd0;
				end
			end
			ST_READ: begin
				mreq.raddr = idx_q;
			end
			ST_READW: begin
				mreq.raddr   = idx_q;
				emit         = slot_free;
				res_d.status = STS_READ;
				if (idx_q < used_q) begin
					res_d.entry_key   = kl_rd.key;
					res_d.entry_line  = kl_rd.line;
					res_d.entry_calls = cb_rd.calls;
					res_d.entry_bytes = cb_rd.bytes;
				end
			end
			ST_PDONE: begin
				emit = slot_free;
				if (rpt_row) begin
					// zero the calls of the emitted entry, keep its bytes
					mreq.we_cb          = slot_free;
					mreq.waddr          = best_idx_q;
					mreq.cb_wdata.bytes = best_bytes_q;
					res_d.status        = STS_REPORT;
					res_d.entry_key     = best_key_q;
					res_d.entry_line    = best_line_q;
					res_d.entry_calls   = peak_calls_q;
					res_d.entry_bytes   = best_bytes_q;
					res_d.last          = 1'b0;
				end else begin
					res_d.status = STS_END;
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			ptr_q      <= '0;
			cmp_vld_s1 <= 1'b0;
			used_q     <= '0;
			drop_q     <= '0;
			rpt_n_q    <= '0;
			ov_q       <= 1'b0;
		end else begin
			if (emit) begin
				ov_q <= 1'b1;
			end else if (result.ready) begin
				ov_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (acc) begin
						ptr_q      <= '0;
						cmp_vld_s1 <= 1'b0;
						rpt_n_q    <= '0;
						case (request.command)
							CMD_RECORD: state_q <= ST_RSCAN;
							CMD_CLEAR:  state_q <= ST_CLR;
							CMD_REPORT: state_q <= ST_PSCAN;
							default:    state_q <= ST_READ;
						endcase
					end
				end
				ST_RSCAN: begin
					if (match) begin
						state_q <= ST_RUPD;
					end else if (!issue) begin
						state_q <= ST_RMISS;
					end else begin
						ptr_q      <= ptr_q + PTR_W'(1);
						cmp_vld_s1 <= 1'b1;
					end
				end
				ST_RMISS: begin
					if (slot_free) begin
						if (full) begin
							drop_q <= drop_inc;
						end else begin
							used_q <= used_q + PTR_W'(1);
						end
						state_q <= ST_IDLE;
					end
				end
				ST_RUPD: begin
					if (slot_free) begin
						state_q <= ST_IDLE;
					end
				end
				ST_CLR: begin
					if (issue) begin
						ptr_q <= ptr_q + PTR_W'(1);
					end else if (slot_free) begin
						drop_q  <= '0;
						state_q <= ST_IDLE;
					end
				end
				ST_READ: begin
					state_q <= ST_READW;
				end
				ST_READW: begin
					if (slot_free) begin
						state_q <= ST_IDLE;
					end
				end
				ST_PSCAN: begin
					if (issue) begin
						ptr_q      <= ptr_q + PTR_W'(1);
						cmp_vld_s1 <= 1'b1;
					end else begin
						// drain the last compare before deciding
						cmp_vld_s1 <= 1'b0;
						if (!cmp_vld_s1) begin
							state_q <= ST_PDONE;
						end
					end
				end
				ST_PDONE: begin
					if (slot_free) begin
						if (rpt_row) begin
							rpt_n_q    <= rpt_n_q + 6'd1;
							ptr_q      <= '0;
							cmp_vld_s1 <= 1'b0;
							state_q    <= ST_PSCAN;
						end else begin
							state_q <= ST_IDLE;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		cmp_idx_s1 <= ptr_q;
		if (acc) begin
			key_q        <= request.site_key;
			line_q       <= request.site_line;
			bytes_in_q   <= request.byte_count;
			lim_q        <= request.report_limit;
			idx_q        <= request.entry_index;
			peak_calls_q <= '0;
		end
		if ((state_q == ST_RSCAN && match) || (state_q == ST_PSCAN && better)) begin
			best_idx_q   <= cmp_idx_s1;
			best_key_q   <= kl_rd.key;
			best_line_q  <= kl_rd.line;
			peak_calls_q <= cb_rd.calls;
			best_bytes_q <= cb_rd.bytes;
		end
		if (state_q == ST_PDONE && slot_free) begin
			peak_calls_q <= '0;
		end
		if (emit) begin
			out_q <= res_d;
		end
	end

	assign result.valid         = ov_q;
	assign result.status        = out_q.status;
	assign result.entry_key     = out_q.entry_key;
	assign result.entry_line    = out_q.entry_line;
	assign result.entry_calls   = out_q.entry_calls;
	assign result.entry_bytes   = out_q.entry_bytes;
	assign result.entries_used  = out_q.entries_used;
	assign result.dropped_calls = out_q.dropped_calls;
	assign result.last          = out_q.last;

	`ASSERT_HOLDS(a_used_bound, used_q <= TE8)
	`ASSERT_NEXT(a_used_mono, 1'b1, used_q >= $past(used_q))
	`ASSERT_IMPL(a_ptr_bound, state_q == ST_RSCAN || state_q == ST_PSCAN || state_q == ST_CLR, ptr_q <= used_q)
	`ASSERT_IMPL(a_rpt_bound, state_q == ST_PDONE, rpt_n_q <= lim_q)
	`ASSERT_NEXT(a_last_idle, emit && res_d.last, state_q == ST_IDLE)
endmodule

// File: src/callsite_tally_table_unit.sv
// channel  | role | payload
// ---------+------+------------------------------------------------------------
// request  | sink | command, site_key, site_line, byte_count, report_limit,
//          |      | entry_index
// result   | src  | status, entry_key, entry_line, entry_calls, entry_bytes,
//          |      | entries_used, dropped_calls, last
//
// One item at a time; each table walk reads one entry a cycle from the two
// single-read-port tables (key/line and calls/bytes).
// Record walks the used entries at most once, then updates or adds one. Clear walks them once.
// Read reads one entry. Report walks the used entries once per emitted entry, plus one final walk.
// Reset leaves the table empty; no clearing pass is needed.
// A stalled result holds the sequencer only when it has the next result ready.
module callsite_tally_table_unit #(
	parameter int unsigned TABLE_ENTRIES = cstt_pkg::TABLE_ENTRIES_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	cstt_in_if.sink     request,
	cstt_out_if.source  result
);
	import cstt_pkg::*;

	localparam int unsigned IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;

	mem_req_t mreq;
	kl_t      kl_rd;
	cb_t      cb_rd;

	cstt_ram #(
		.WIDTH ($bits(kl_t)),
		.DEPTH (TABLE_ENTRIES),
		.AW    (IDX_W)
	) u_kl_ram (
		.clk   (clk),
		.we    (mreq.we_kl),
		.waddr (mreq.waddr[IDX_W-1:0]),
		.wdata (mreq.kl_wdata),
		.raddr (mreq.raddr[IDX_W-1:0]),
		.rdata (kl_rd)
	);

	cstt_ram #(
		.WIDTH ($bits(cb_t)),
		.DEPTH (TABLE_ENTRIES),
		.AW    (IDX_W)
	) u_cb_ram (
		.clk   (clk),
		.we    (mreq.we_cb),
		.waddr (mreq.waddr[IDX_W-1:0]),
		.wdata (mreq.cb_wdata),
		.raddr (mreq.raddr[IDX_W-1:0]),
		.rdata (cb_rd)
	);

	cstt_seq #(
		.TABLE_ENTRIES (TABLE_ENTRIES)
	) u_seq (
		.clk     (clk),
		.arst_n  (arst_n),
		.request (request),
		.result  (result),
		.mreq    (mreq),
		.kl_rd   (kl_rd),
		.cb_rd   (cb_rd)
	);
endmodule
